>>> sv/assert_macros.svh
// Assertion macros for the line junction detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ljd_pkg.sv
// Shared types and constants of the line junction detector.
`timescale 1ns / 1ps
`default_nettype none

package ljd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 13;
    localparam int THRESH_W = 13;
    localparam int CMP_W    = 14;
    localparam int COUNT_W  = 8;

    localparam int HISTORY_DEPTH_DEF  = 4;
    localparam int SETTLE_SAMPLES_DEF = 8;

    localparam logic [SAMPLE_W-1:0] EMPTY_MIDDLE         = 12'd2000;
    localparam logic [THRESH_W-1:0] EDGE_THRESHOLD_RESET = 13'd100;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_BOTH  = 3'd1,
        ST_RIGHT = 3'd2,
        ST_LEFT  = 3'd3,
        ST_LINE  = 3'd4
    } track_state_t;

    typedef enum logic [2:0] {
        EV_LINE       = 3'd0,
        EV_NO_LINE    = 3'd1,
        EV_OPT_RIGHT  = 3'd2,
        EV_RIGHT_TURN = 3'd3,
        EV_OPT_LEFT   = 3'd4,
        EV_LEFT_TURN  = 3'd5,
        EV_SPLIT      = 3'd6,
        EV_CROSS      = 3'd7
    } road_event_t;

endpackage

`default_nettype wire

>>> sv/line_junction_detector_core.sv
// Top level of the line junction detector: sample register, logic, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The core takes one word of five reflectance samples per clock cycle and
// returns one word with the line status and the road event for it. A word
// is captured in the sample register (with the left and right pair sums
// already formed), then classified against the oldest history entries and
// run through the road state machine combinationally, and the result is
// captured in the result register; throughput is one word per cycle as
// long as m_ready is high. Histories and road state advance exactly when a
// word moves from the sample register into the result register. The
// threshold register is written with cfg_wr_en and should only be changed
// while no words are in flight.
module line_junction_detector_core
    import ljd_pkg::*;
#(
    parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF,
    parameter int SETTLE_SAMPLES = SETTLE_SAMPLES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [THRESH_W-1:0] cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [SAMPLE_W-1:0] s_left_outer_sample,
    input  wire logic [SAMPLE_W-1:0] s_left_inner_sample,
    input  wire logic [SAMPLE_W-1:0] s_middle_sample,
    input  wire logic [SAMPLE_W-1:0] s_right_inner_sample,
    input  wire logic [SAMPLE_W-1:0] s_right_outer_sample,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_track_state,
    output logic [2:0]               m_road_event
);

    logic [THRESH_W-1:0] edge_threshold_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] middle_reg;
    logic [SUM_W-1:0]    left_sum_reg;
    logic [SUM_W-1:0]    right_sum_reg;
    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [2:0]          event_reg;
    logic                advance;
    track_state_t        status;
    road_event_t         road_event;

    // A word moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_threshold_reg <= EDGE_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            edge_threshold_reg <= cfg_wr_data;
        end
    end

    // Sample register with the pair sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            middle_reg    <= s_middle_sample;
            left_sum_reg  <= SUM_W'(s_left_outer_sample) + SUM_W'(s_left_inner_sample);
            right_sum_reg <= SUM_W'(s_right_inner_sample) + SUM_W'(s_right_outer_sample);
        end
    end

    ljd_classify #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_classify (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .edge_threshold (edge_threshold_reg),
        .middle         (middle_reg),
        .left_sum       (left_sum_reg),
        .right_sum      (right_sum_reg),
        .status         (status)
    );

    ljd_road #(
        .SETTLE_SAMPLES (SETTLE_SAMPLES)
    ) u_road (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .status     (status),
        .road_event (road_event)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status;
            event_reg  <= road_event;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_track_state = status_reg;
    assign m_road_event  = event_reg;

    // Losing the line clears the on-track flag, so no option or cross follows.
    `ASSERT_CLK(a_no_line_event, aclk, aresetn,
        m_valid && (m_track_state == ST_NONE) |-> (m_road_event != EV_OPT_RIGHT) &&
        (m_road_event != EV_OPT_LEFT) && (m_road_event != EV_CROSS),
        "option or cross reported on a word without line")

    // A full pipeline with a stalled sink keeps both words.
    `ASSERT_CLK(a_hold_full, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && out_valid_reg,
        "word dropped while the result side stalls")

    // Input side only stalls when both registers are occupied.
    `ASSERT_ALWAYS(a_stall_cause, aclk,
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready,
        "input stalled without a full pipeline")

endmodule

`default_nettype wire

>>> sv/ljd_classify.sv
// Line status classification against the sample histories.
`timescale 1ns / 1ps
`default_nettype none

module ljd_classify
    import ljd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire logic [THRESH_W-1:0] edge_threshold,
    input  wire logic [SAMPLE_W-1:0] middle,
    input  wire logic [SUM_W-1:0]    left_sum,
    input  wire logic [SUM_W-1:0]    right_sum,
    output track_state_t             status
);

    localparam int OLDEST = HISTORY_DEPTH - 1;

    logic [SAMPLE_W-1:0] middle_hist_reg [HISTORY_DEPTH];
    logic [SUM_W-1:0]    left_hist_reg   [HISTORY_DEPTH];
    logic [SUM_W-1:0]    right_hist_reg  [HISTORY_DEPTH];

    logic [SAMPLE_W-1:0] middle_ref;
    logic [CMP_W-1:0]    middle_limit;
    logic [CMP_W-1:0]    left_lhs;
    logic [CMP_W-1:0]    right_lhs;
    logic                on_line;
    logic                left_edge;
    logic                right_edge;

    // An empty oldest middle entry stands for a bright background.
    assign middle_ref = (middle_hist_reg[OLDEST] == '0) ? EMPTY_MIDDLE
                                                       : middle_hist_reg[OLDEST];

    // All operands are non-negative, so the signed compares of the sums are
    // rewritten with the threshold moved to the other side.
    assign middle_limit = CMP_W'(middle_ref) + CMP_W'(edge_threshold);
    assign left_lhs     = CMP_W'(left_sum) + CMP_W'(edge_threshold);
    assign right_lhs    = CMP_W'(right_sum) + CMP_W'(edge_threshold);

    assign on_line    = (CMP_W'(middle) <= middle_limit);
    assign left_edge  = (left_lhs < CMP_W'(left_hist_reg[OLDEST]));
    assign right_edge = (right_lhs < CMP_W'(right_hist_reg[OLDEST]));

    // Status in priority order.
    always_comb begin
        priority if (!on_line) begin
            status = ST_NONE;
        end else if (left_edge && right_edge) begin
            status = ST_BOTH;
        end else if (right_edge) begin
            status = ST_RIGHT;
        end else if (left_edge) begin
            status = ST_LEFT;
        end else begin
            status = ST_LINE;
        end
    end

    // Histories shift on each word; side histories flush on an edge, the middle one off the line.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                middle_hist_reg[i] <= '0;
                left_hist_reg[i]   <= '0;
                right_hist_reg[i]  <= '0;
            end
        end else if (advance) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                middle_hist_reg[i] <= on_line ? middle_hist_reg[i-1] : EMPTY_MIDDLE;
                left_hist_reg[i]   <= left_edge ? '0 : left_hist_reg[i-1];
                right_hist_reg[i]  <= right_edge ? '0 : right_hist_reg[i-1];
            end
            middle_hist_reg[0] <= middle;
            left_hist_reg[0]   <= left_sum;
            right_hist_reg[0]  <= right_sum;
        end
    end

endmodule

`default_nettype wire

>>> sv/ljd_road.sv
// Road state machine: side counters, hold-off counter and track flags.
`timescale 1ns / 1ps
`default_nettype none

module ljd_road
    import ljd_pkg::*;
#(
    parameter int SETTLE_SAMPLES = SETTLE_SAMPLES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         advance,
    input  wire track_state_t status,
    output road_event_t       road_event
);

    localparam logic [COUNT_W-1:0] SETTLE = COUNT_W'(SETTLE_SAMPLES);

    logic [COUNT_W-1:0] left_cnt_reg,  left_cnt_next;
    logic [COUNT_W-1:0] right_cnt_reg, right_cnt_next;
    logic [COUNT_W-1:0] hold_cnt_reg,  hold_cnt_next;
    logic               on_track_reg,  on_track_next;
    logic               cross_reg,     cross_next;
    logic               done;

    // Next state and event for the current status.
    always_comb begin
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        hold_cnt_next  = hold_cnt_reg;
        on_track_next  = on_track_reg;
        cross_next     = cross_reg;
        road_event     = EV_LINE;
        done           = 1'b0;

        // Side and junction bookkeeping for the new status.
        unique case (status)
            ST_NONE: begin
                on_track_next = 1'b0;
            end
            ST_BOTH: begin
                if (hold_cnt_next == '0) begin
                    cross_next    = 1'b1;
                    hold_cnt_next = COUNT_W'(1);
                end
            end
            ST_LEFT: begin
                if (right_cnt_next != '0) begin
                    if (hold_cnt_next == '0) begin
                        cross_next     = 1'b1;
                        hold_cnt_next  = COUNT_W'(1);
                        right_cnt_next = '0;
                    end
                end else if (hold_cnt_next == '0) begin
                    left_cnt_next = left_cnt_next + COUNT_W'(1);
                end
            end
            ST_RIGHT: begin
                if (left_cnt_next != '0) begin
                    if (hold_cnt_next == '0) begin
                        cross_next    = 1'b1;
                        hold_cnt_next = COUNT_W'(1);
                        left_cnt_next = '0;
                    end
                end else if (hold_cnt_next == '0) begin
                    right_cnt_next = right_cnt_next + COUNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        // A right side that persisted long enough is an option or a turn.
        if (right_cnt_next != '0) begin
            if (right_cnt_next > SETTLE) begin
                right_cnt_next = '0;
                done           = 1'b1;
                if (hold_cnt_next == '0 && on_track_next) begin
                    hold_cnt_next = COUNT_W'(1);
                    road_event    = EV_OPT_RIGHT;
                end else begin
                    road_event = EV_RIGHT_TURN;
                end
            end else begin
                right_cnt_next = right_cnt_next + COUNT_W'(1);
            end
        end

        // The same for the left side.
        if (!done && left_cnt_next != '0) begin
            if (left_cnt_next > SETTLE) begin
                left_cnt_next = '0;
                done          = 1'b1;
                if (hold_cnt_next == '0 && on_track_next) begin
                    hold_cnt_next = COUNT_W'(1);
                    road_event    = EV_OPT_LEFT;
                end else begin
                    road_event = EV_LEFT_TURN;
                end
            end else begin
                left_cnt_next = left_cnt_next + COUNT_W'(1);
            end
        end

        // A pending junction is reported once the hold-off has run out.
        if (!done && hold_cnt_next == '0 && cross_next) begin
            cross_next = 1'b0;
            done       = 1'b1;
            road_event = on_track_next ? EV_CROSS : EV_SPLIT;
        end

        // Losing the line is reported once everything has settled.
        if (!done && !on_track_next && hold_cnt_next == '0 &&
            left_cnt_next == '0 && right_cnt_next == '0) begin
            on_track_next = 1'b1;
            done          = 1'b1;
            road_event    = EV_NO_LINE;
        end

        // A started hold-off counter runs on every word that reports no event.
        if (!done && hold_cnt_next != '0) begin
            hold_cnt_next = hold_cnt_next + COUNT_W'(1);
            if (hold_cnt_next > SETTLE) begin
                hold_cnt_next = '0;
            end
        end
    end

    // Road state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            hold_cnt_reg  <= '0;
            on_track_reg  <= 1'b1;
            cross_reg     <= 1'b0;
        end else if (advance) begin
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            hold_cnt_reg  <= hold_cnt_next;
            on_track_reg  <= on_track_next;
            cross_reg     <= cross_next;
        end
    end

endmodule

`default_nettype wire
